// ----- rtl/core/subarray_sum_count_defines.svh -----
// assertion macros for the subarray sum counter
`ifndef SUBARRAY_SUM_COUNT_DEFINES_SVH
`define SUBARRAY_SUM_COUNT_DEFINES_SVH

// same-cycle implication on clk, off during rst
`define SSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off during rst
`define SSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ssc_pkg.sv -----
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int TARGET_W = 26;
  localparam int TOTAL_W  = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  localparam int HASH_W      = 64;
  localparam int HASH_STEP_W = $clog2(HASH_W);
  localparam int HASH_SHIFT  = 29;
  localparam logic [31:0] HASH_MULT_LO = 32'h7F4A7C15;
  localparam logic [31:0] HASH_MULT_HI = 32'h9E3779B9;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_SEED,
    ST_IDLE,
    ST_KEY,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/core/ssc_if.sv -----
`timescale 1ns / 1ps

interface ssc_in_if #(
  parameter int VALUE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         last;

  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface ssc_out_if
  import ssc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] match_total;
  logic               overflow;
  logic               done_res;

  modport source (output valid, match_total, overflow, done_res, input ready);
  modport sink (input valid, match_total, overflow, done_res, output ready);
endinterface

// ----- rtl/core/ssc_ram.sv -----
`timescale 1ns / 1ps

module ssc_ram #(
  parameter int WIDTH = 46,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/subarray_sum_count.sv -----
`timescale 1ns / 1ps
// Counts the contiguous runs of signed elements whose sum equals target_sum. Each element
// transfer updates a prefix sum, looks up (sum - target_sum) in a linear-probing hash
// table of prefix-sum counts, adds the count found to a saturating 20-bit total, then
// bumps or inserts the entry for the current sum, and returns one result with the total.
// One shared 32x32 multiplier forms the 64-bit hash in states ST_MUL0, ST_MUL1, ST_MUL2.
// An element past MAX_LEN is ignored and only flags overflow in its result; any other
// element hashes twice, for the lookup and for the update. A power-of-two TABLE_SIZE takes
// the low hash bits as the index, any other size a bit-serial remainder over all 64 bits.
// The table is one RAM with a registered read port, so every probe step is a read state
// and then a check state. Entries carry an array tag; after reset, and after every 255th
// array, a clearing pass writes the whole table (2048 entries by default), during which no
// element is taken. A seed state after that pass and after each array writes the empty sum.
`include "subarray_sum_count_defines.svh"

module subarray_sum_count
  import ssc_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int TABLE_SIZE = 2048,
  parameter int VALUE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic signed [TARGET_W-1:0] cfg_wr_data,
  ssc_in_if.sink                     elem,
  ssc_out_if.source                  result
);

  localparam int SUM_W  = VALUE_BITS + $clog2(MAX_LEN) + 1;
  localparam int KEY_W  = ((SUM_W > TARGET_W) ? SUM_W : TARGET_W) + 1;
  localparam int CNT_W  = $clog2(MAX_LEN + 2);
  localparam int ELEM_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int MEM_W  = EPOCH_W + SUM_W + CNT_W;
  localparam bit TBL_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  state_t state, state_next;

  logic signed [TARGET_W-1:0] target;
  logic signed [SUM_W-1:0]    run_sum;
  logic [TOTAL_W-1:0]         total;
  logic [ELEM_W-1:0]          elem_cnt;
  logic                       overflow_seen;
  logic [EPOCH_W-1:0]         epoch;
  logic [IDX_W-1:0]           clr_idx;
  logic                       res_valid;

  logic                     last_q;
  logic                     phase;
  logic signed [KEY_W-1:0]  key;
  logic [HASH_W-1:0]        acc;
  logic [IDX_W-1:0]         rem;
  logic [HASH_STEP_W-1:0]   bit_cnt;
  logic [IDX_W-1:0]         probe_idx;
  logic [IDX_W-1:0]         probe_n;
  logic [TOTAL_W-1:0]       res_total;
  logic                     res_overflow;
  logic                     res_done;

  logic              accept;
  logic              ignore;
  logic [SUM_W-1:0]  value_ext;
  logic [KEY_W-1:0]  sum_ext;
  logic [KEY_W-1:0]  target_ext;
  logic [HASH_W-1:0] key64;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [HASH_W-1:0] mixed;
  logic [IDX_W:0]    rem_shift;
  logic [IDX_W:0]    rem_sub;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [MEM_W-1:0]        ram_wdata;
  logic [MEM_W-1:0]        rd_data;
  logic [EPOCH_W-1:0]      ent_tag;
  logic signed [SUM_W-1:0] ent_key;
  logic [CNT_W-1:0]        ent_cnt;
  logic [CNT_W-1:0]        ent_cnt_inc;
  logic                    ent_valid;
  logic                    ent_match;
  logic                    probe_done;
  logic [TOTAL_W:0]        tot_sum;
  logic                    res_free;

  assign accept     = elem.valid && elem.ready;
  assign ignore     = (elem_cnt >= ELEM_W'(MAX_LEN));
  assign value_ext  = {{(SUM_W - VALUE_BITS){elem.value[VALUE_BITS-1]}}, elem.value};
  assign sum_ext    = {{(KEY_W - SUM_W){run_sum[SUM_W-1]}}, run_sum};
  assign target_ext = {{(KEY_W - TARGET_W){target[TARGET_W-1]}}, target};
  assign key64      = {{(HASH_W - KEY_W){key[KEY_W-1]}}, key};

  // shared multiplier for the 64-bit hash product
  always_comb begin
    case (state)
      ST_MUL1: begin
        mul_a = key64[63:32];
        mul_b = HASH_MULT_LO;
      end
      ST_MUL2: begin
        mul_a = key64[31:0];
        mul_b = HASH_MULT_HI;
      end
      default: begin
        mul_a = key64[31:0];
        mul_b = HASH_MULT_LO;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign mixed     = acc ^ (acc >> HASH_SHIFT);
  assign rem_shift = {rem, acc[HASH_W-1]};
  assign rem_sub   = (rem_shift >= (IDX_W + 1)'(TABLE_SIZE)) ?
                     rem_shift - (IDX_W + 1)'(TABLE_SIZE) : rem_shift;

  assign ent_tag     = rd_data[MEM_W-1 -: EPOCH_W];
  assign ent_key     = rd_data[CNT_W +: SUM_W];
  assign ent_cnt     = rd_data[CNT_W-1:0];
  assign ent_cnt_inc = (ent_cnt == '1) ? ent_cnt : ent_cnt + 1'b1;
  assign ent_valid   = (ent_tag == epoch);
  assign ent_match   = ent_valid &&
                       ({{(KEY_W - SUM_W){ent_key[SUM_W-1]}}, ent_key} == key);
  assign probe_done  = !ent_valid || ent_match || (probe_n == LAST_IDX);
  assign tot_sum     = {1'b0, total} + (TOTAL_W + 1)'(ent_cnt);
  assign res_free    = !res_valid || result.ready;

  ssc_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe_idx),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_IDX) begin
          state_next = ST_SEED;
        end
      end
      ST_SEED: state_next = ST_IDLE;
      ST_IDLE: begin
        if (elem.valid) begin
          state_next = ignore ? ST_FINISH : ST_KEY;
        end
      end
      ST_KEY:  state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MIX;
      ST_MIX:  state_next = TBL_POW2 ? ST_READ : ST_MOD;
      ST_MOD: begin
        if (bit_cnt == '1) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_CHECK;
      ST_CHECK: begin
        if (probe_done) begin
          state_next = phase ? ST_FINISH : ST_KEY;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          if (!last_q) begin
            state_next = ST_IDLE;
          end else if (epoch == EPOCH_MAX) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_SEED;
          end
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs and table writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = probe_idx;
    ram_wdata = {epoch, run_sum, CNT_W'(1)};
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      ST_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {epoch, {SUM_W{1'b0}}, CNT_W'(1)};
      end
      ST_CHECK: begin
        if (phase && ent_match) begin
          ram_we    = 1'b1;
          ram_wdata = {epoch, ent_key, ent_cnt_inc};
        end else if (phase && !ent_valid) begin
          ram_we    = 1'b1;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign elem.ready         = (state == ST_IDLE);
  assign result.valid       = res_valid;
  assign result.match_total = res_total;
  assign result.overflow    = res_overflow;
  assign result.done_res    = res_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      target        <= '0;
      run_sum       <= '0;
      total         <= '0;
      elem_cnt      <= '0;
      overflow_seen <= 1'b0;
      epoch         <= '0;
      clr_idx       <= '0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        target <= cfg_wr_data;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            epoch <= EPOCH_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (ignore) begin
              overflow_seen <= 1'b1;
            end else begin
              elem_cnt <= elem_cnt + 1'b1;
              run_sum  <= run_sum + value_ext;
            end
          end
        end
        ST_CHECK: begin
          if (!phase && ent_match) begin
            total <= tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
          end
        end
        ST_FINISH: begin
          if (res_free && last_q) begin
            run_sum       <= '0;
            total         <= '0;
            elem_cnt      <= '0;
            overflow_seen <= 1'b0;
            clr_idx       <= '0;
            if (epoch != EPOCH_MAX) begin
              epoch <= epoch + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      if (state == ST_FINISH && res_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        last_q <= elem.last;
        phase  <= 1'b0;
      end
      ST_KEY: begin
        key <= phase ? sum_ext : sum_ext - target_ext;
      end
      ST_MUL0: acc <= mul_p;
      ST_MUL1: acc[63:32] <= acc[63:32] + mul_p[31:0];
      ST_MUL2: acc[63:32] <= acc[63:32] + mul_p[31:0];
      ST_MIX: begin
        acc       <= mixed;
        probe_idx <= mixed[IDX_W-1:0];
        rem       <= '0;
        bit_cnt   <= '0;
        probe_n   <= '0;
      end
      ST_MOD: begin
        acc       <= acc << 1;
        rem       <= rem_sub[IDX_W-1:0];
        probe_idx <= rem_sub[IDX_W-1:0];
        bit_cnt   <= bit_cnt + 1'b1;
      end
      ST_CHECK: begin
        if (probe_done) begin
          phase <= 1'b1;
        end else begin
          probe_idx <= (probe_idx == LAST_IDX) ? '0 : probe_idx + 1'b1;
          probe_n   <= probe_n + 1'b1;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          res_total    <= total;
          res_overflow <= overflow_seen;
          res_done     <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  `SSC_ASSERT_NEXT(a_total_grows, state != ST_FINISH, total >= $past(total), "total dropped")
  `SSC_ASSERT_NEXT(a_ignored, accept && ignore, state == ST_FINISH && overflow_seen, "bad ignore")
  `SSC_ASSERT_NEXT(a_seed, state == ST_CLEAR && clr_idx == LAST_IDX, state == ST_SEED && epoch == EPOCH_W'(1), "bad clear end")
  `SSC_ASSERT_IMPL(a_probe_write, ram_we && state == ST_CHECK, phase, "write in lookup")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ssc_pkg::*;

  localparam int MAX_LEN      = 1024;
  localparam int TABLE_SIZE   = 2048;
  localparam int VALUE_BITS   = 16;
  localparam int IDLE_MARGIN  = 16;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int MIN_ARRAYS   = 260;
  localparam int PHASE_ARRAYS = 40;
  localparam int REPORT_LIMIT = 10;

  typedef enum {ROW_ELEM, ROW_CFG} row_kind_t;
  typedef enum {VAL_SMALL, VAL_FULL, VAL_EXTREME, VAL_MIXED} value_mode_t;

  typedef struct {
    logic [TOTAL_W-1:0] match_total;
    logic               overflow;
    logic               done_res;
  } match_result_t;

  typedef struct {
    row_kind_t   kind;
    int          data;
    bit          last;
    bit          typed;
    int unsigned total;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ELEM, 0, 1'b0, 1'b1, 1},
    '{ROW_ELEM, 0, 1'b1, 1'b1, 3},
    '{ROW_ELEM, 32767, 1'b0, 1'b1, 0},
    '{ROW_ELEM, -32768, 1'b0, 1'b1, 0},
    '{ROW_ELEM, 1, 1'b0, 1'b1, 1},
    '{ROW_ELEM, -1, 1'b1, 1'b0, 0},
    '{ROW_ELEM, -32768, 1'b1, 1'b1, 0},
    '{ROW_CFG, 5, 1'b0, 1'b0, 0},
    '{ROW_ELEM, 2, 1'b0, 1'b1, 0},
    '{ROW_ELEM, 3, 1'b0, 1'b1, 1},
    '{ROW_ELEM, 0, 1'b1, 1'b1, 2},
    '{ROW_CFG, 33554431, 1'b0, 1'b0, 0},
    '{ROW_ELEM, 32767, 1'b1, 1'b1, 0},
    '{ROW_CFG, -33554432, 1'b0, 1'b0, 0},
    '{ROW_ELEM, -32768, 1'b1, 1'b1, 0},
    '{ROW_CFG, -1, 1'b0, 1'b0, 0},
    '{ROW_ELEM, -1, 1'b0, 1'b1, 1},
    '{ROW_ELEM, 0, 1'b0, 1'b0, 0},
    '{ROW_ELEM, 1, 1'b1, 1'b0, 0},
    '{ROW_CFG, 0, 1'b0, 1'b0, 0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en;
  logic signed [TARGET_W-1:0] cfg_wr_data;

  ssc_in_if #(.VALUE_BITS(VALUE_BITS)) elem_if ();
  ssc_out_if result_if ();

  subarray_sum_count #(
    .MAX_LEN   (MAX_LEN),
    .TABLE_SIZE(TABLE_SIZE),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .elem       (elem_if),
    .result     (result_if)
  );

  always #2 clk = ~clk;

  longint          target_now = 0;
  longint          prefix_sum;
  int unsigned     run_total;
  int unsigned     run_length;
  bit              run_overflow;
  int unsigned     prefix_hits [longint];
  match_result_t   expected_results [$];
  int unsigned     failures = 0;
  int unsigned     cycle_count = 0;
  int unsigned     items_sent = 0;
  bit              source_pauses = 1'b1;
  bit              sink_pauses = 1'b1;

  function automatic void start_new_array();
    prefix_sum   = 0;
    run_total    = 0;
    run_length   = 0;
    run_overflow = 1'b0;
    prefix_hits.delete();
    prefix_hits[0] = 1;
  endfunction

  function automatic match_result_t predict_match(input logic signed [VALUE_BITS-1:0] v,
                                                  input logic l);
    match_result_t   r;
    longint          key;
    longint unsigned grown;
    if (run_length >= MAX_LEN) begin
      run_overflow = 1'b1;
    end else begin
      run_length++;
      prefix_sum += longint'(v);
      key = prefix_sum - target_now;
      if (prefix_hits.exists(key)) begin
        grown = run_total;
        grown += prefix_hits[key];
        run_total = (grown > TOTAL_MAX) ? TOTAL_MAX : grown[31:0];
      end
      if (prefix_hits.exists(prefix_sum)) begin
        if (prefix_hits[prefix_sum] != 32'hFFFF_FFFF) prefix_hits[prefix_sum]++;
      end else begin
        prefix_hits[prefix_sum] = 1;
      end
    end
    r.match_total = run_total[TOTAL_W-1:0];
    r.overflow    = run_overflow;
    r.done_res    = l;
    if (l) start_new_array();
    return r;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value(input value_mode_t mode);
    value_mode_t m;
    m = mode;
    if (m == VAL_MIXED) m = value_mode_t'($urandom_range(0, 2));
    case (m)
      VAL_SMALL: return VALUE_BITS'($urandom_range(0, 6) - 3);
      VAL_FULL:  return VALUE_BITS'($urandom());
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          3:       return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [TARGET_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      6:       return {1'b0, {(TARGET_W-1){1'b1}}};
      7:       return {1'b1, {(TARGET_W-1){1'b0}}};
      8:       return TARGET_W'($urandom());
      9:       return TARGET_W'($urandom_range(0, 200) - 100);
      default: return TARGET_W'($urandom_range(0, 12) - 6);
    endcase
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(13, 48);
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic send_elem(input logic signed [VALUE_BITS-1:0] v, input logic l,
                           input bit typed, input int unsigned typed_total);
    int            gap;
    match_result_t want;
    gap = source_pauses ? $urandom_range(0, 5) : 0;
    if ($urandom_range(0, 49) == 0) source_pauses = !source_pauses;
    if (gap > 0) begin
      elem_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    elem_if.valid <= 1'b1;
    elem_if.value <= v;
    elem_if.last  <= l;
    want = predict_match(v, l);
    if (typed) begin
      want.match_total = typed_total[TOTAL_W-1:0];
      want.overflow    = 1'b0;
    end
    expected_results.push_back(want);
    items_sent++;
    do @(posedge clk); while (elem_if.ready !== 1'b1);
  endtask

  task automatic send_array(input int len, input value_mode_t mode);
    for (int i = 0; i < len; i++) begin
      send_elem(pick_value(mode), i == len - 1, 1'b0, 0);
    end
  endtask

  // target changes only once the block has drained
  task automatic write_target(input logic signed [TARGET_W-1:0] t);
    elem_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (IDLE_MARGIN) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    target_now = t;
  endtask

  initial begin : result_sink
    int            stall;
    match_result_t want;
    result_if.ready = 1'b0;
    forever begin
      stall = sink_pauses ? $urandom_range(0, 5) : 0;
      if ($urandom_range(0, 49) == 0) sink_pauses = !sink_pauses;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (result_if.valid !== 1'b1);
      if (expected_results.size() == 0) begin
        report_failure($sformatf("unexpected result transfer: total %0d overflow %0b done %0b",
                                 result_if.match_total, result_if.overflow,
                                 result_if.done_res));
      end else begin
        want = expected_results.pop_front();
        if (result_if.match_total !== want.match_total ||
            result_if.overflow !== want.overflow ||
            result_if.done_res !== want.done_res) begin
          report_failure($sformatf(
            "mismatch: expected total %0d overflow %0b done %0b, got %0d %0b %0b",
            want.match_total, want.overflow, want.done_res,
            result_if.match_total, result_if.overflow, result_if.done_res));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("subarray_sum_count test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int arrays_sent;
    elem_if.valid = 1'b0;
    elem_if.value = '0;
    elem_if.last  = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    start_new_array();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_target(directed_rows[i].data[TARGET_W-1:0]);
      end else begin
        send_elem(directed_rows[i].data[VALUE_BITS-1:0], directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].total);
      end
    end

    // too many elements, last transfer lands on an ignored one
    items_sent = 0;
    send_array(MAX_LEN + 4, VAL_MIXED);

    arrays_sent = 0;
    while (items_sent < RANDOM_ITEMS || arrays_sent < MIN_ARRAYS) begin
      if (arrays_sent % PHASE_ARRAYS == 0) write_target(pick_target());
      send_array(pick_length(), value_mode_t'($urandom_range(0, 3)));
      arrays_sent++;
    end

    elem_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("subarray_sum_count test passed");
    end else begin
      $display("subarray_sum_count test failed");
    end
    $finish;
  end

endmodule
